// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl top level
// expects aclk and aresetn to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check of a plain expression, sampled on the rising edge, off during reset
`define NRB_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// implication check, sampled on the rising edge, off during reset
`define NRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nrb_pkg.sv -----
// shared types, constants and codes for the nkro report builder
// no dependencies
`default_nettype none

package nrb_pkg;

    localparam int NUM_KEYS     = 77;
    localparam int REPORT_BYTES = 16;

    localparam int KEY_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int BYTE_W      = $clog2(REPORT_BYTES);
    localparam int BITMAP_BITS = (REPORT_BYTES - 2) * 8;
    localparam int CHUNK_BITS  = 32;

    localparam logic [7:0] USAGE_FIRST = 8'h04;

    // input operation codes
    typedef enum logic [1:0] {
        OP_BASE  = 2'd0,
        OP_FN    = 2'd1,
        OP_REARM = 2'd2,
        OP_KEY   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAP_VALID = 2'd0,
        CFG_FN_ENABLE = 2'd1,
        CFG_FN_KEY    = 2'd2,
        CFG_SPARE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              accept;
        logic              clear;
        logic              rd_en;
        logic [KEY_W-1:0]  rd_key;
        logic [BYTE_W-1:0] byte_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic map_valid;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/nrb_ctrl.sv -----
// controller: sequences accept, key walk, drain and byte emission
// depends on nrb_pkg
`default_nettype none

module nrb_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_op,
    input  wire logic            s_last_chunk,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [3:0]           m_byte_index,
    output logic                 m_last_byte,
    input  wire nrb_pkg::status_t status,
    output nrb_pkg::cmd_t        cmd
);
    import nrb_pkg::*;

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              accept;
    logic              start;
    logic              key_last;
    logic              byte_last;

    assign accept    = s_valid && s_ready;
    assign start     = accept && (s_op == OP_KEY) && s_last_chunk;
    assign key_last  = (key_reg == KEY_W'(NUM_KEYS - 1));
    assign byte_last = (byte_reg == BYTE_W'(REPORT_BYTES - 1));

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            key_reg   <= '0;
            byte_reg  <= '0;
        end else begin
            state_reg <= state_next;
            key_reg   <= key_next;
            byte_reg  <= byte_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        byte_next  = byte_reg;
        case (state_reg)
            ST_IDLE: begin
                key_next  = '0;
                byte_next = '0;
                if (start) begin
                    state_next = status.map_valid ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK: begin
                if (key_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    key_next = key_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (byte_last) begin
                        state_next = ST_IDLE;
                        byte_next  = '0;
                    end else begin
                        byte_next = byte_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_EMIT);
        m_byte_index = 4'(byte_reg);
        m_last_byte  = byte_last;
        cmd.accept   = accept;
        cmd.clear    = start;
        cmd.rd_en    = (state_reg == ST_WALK);
        cmd.rd_key   = key_reg;
        cmd.byte_idx = byte_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/nrb_datapath.sv -----
// datapath: key maps, key-down and rearm bits, config, report build and byte select
// depends on nrb_pkg
`default_nettype none

module nrb_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire nrb_pkg::cmd_t cmd,
    output nrb_pkg::status_t   status,
    input  wire logic [1:0]    s_op,
    input  wire logic [6:0]    s_key_index,
    input  wire logic [7:0]    s_usage_code,
    input  wire logic [7:0]    s_modifier_bits,
    input  wire logic [1:0]    s_chunk_index,
    input  wire logic [31:0]   s_key_bits,
    input  wire logic          cfg_valid,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    output logic [7:0]         m_byte_value
);
    import nrb_pkg::*;

    // configuration registers
    logic       map_valid_reg;
    logic       fn_enable_reg;
    logic [7:0] fn_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= 1'b0;
            fn_enable_reg <= 1'b0;
            fn_key_reg    <= 8'hFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAP_VALID: map_valid_reg <= cfg_data[0];
                CFG_FN_ENABLE: fn_enable_reg <= cfg_data[0];
                CFG_FN_KEY:    fn_key_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign status.map_valid = map_valid_reg;

    // map memories, one {usage, modifier} word per key
    logic [15:0]         base_mem [NUM_KEYS];
    logic [15:0]         fn_mem   [NUM_KEYS];
    logic [NUM_KEYS-1:0] base_vld_reg;
    logic [NUM_KEYS-1:0] fn_vld_reg;
    logic [15:0]         base_rd_reg;
    logic [15:0]         fn_rd_reg;
    logic                base_rv_reg;
    logic                fn_rv_reg;
    logic [KEY_W-1:0]    wr_key;
    logic                key_ok;
    logic                wr_base;
    logic                wr_fn;

    assign wr_key  = KEY_W'(s_key_index);
    assign key_ok  = ({1'b0, s_key_index} < 8'(NUM_KEYS));
    assign wr_base = cmd.accept && (s_op == OP_BASE) && key_ok;
    assign wr_fn   = cmd.accept && (s_op == OP_FN) && key_ok;

    always_ff @(posedge aclk) begin
        if (wr_base) begin
            base_mem[wr_key] <= {s_usage_code, s_modifier_bits};
        end
        if (wr_fn) begin
            fn_mem[wr_key] <= {s_usage_code, s_modifier_bits};
        end
        if (cmd.rd_en) begin
            base_rd_reg <= base_mem[cmd.rd_key];
            fn_rd_reg   <= fn_mem[cmd.rd_key];
        end
    end

    // per-entry written flags, unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_vld_reg <= '0;
            fn_vld_reg   <= '0;
        end else begin
            if (wr_base) begin
                base_vld_reg[wr_key] <= 1'b1;
            end
            if (wr_fn) begin
                fn_vld_reg[wr_key] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            base_rv_reg <= base_vld_reg[cmd.rd_key];
            fn_rv_reg   <= fn_vld_reg[cmd.rd_key];
        end
    end

    // read pipeline tag
    logic             vld_d_reg;
    logic [KEY_W-1:0] key_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_d_reg <= 1'b0;
        end else begin
            vld_d_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        key_d_reg <= cmd.rd_key;
    end

    // key-down and rearm bits
    logic [NUM_KEYS-1:0] key_down_reg;
    logic [NUM_KEYS-1:0] rearm_reg;
    logic                kd;
    logic                rm;
    logic                layer_on;
    logic                is_fn_key;
    logic                fn_key_ok;
    logic [15:0]         base_ent;
    logic [15:0]         fn_ent;
    logic [15:0]         sel_ent;
    logic                contrib;
    logic [7:0]          ubit;
    logic                bit_hit;

    assign kd        = key_down_reg[key_d_reg];
    assign rm        = rearm_reg[key_d_reg];
    assign fn_key_ok = (fn_key_reg < 8'(NUM_KEYS));
    assign layer_on  = fn_enable_reg && fn_key_ok && key_down_reg[KEY_W'(fn_key_reg)];
    assign is_fn_key = layer_on && (fn_key_reg == 8'(key_d_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_down_reg <= '0;
            rearm_reg    <= '0;
        end else if (cmd.accept && (s_op == OP_KEY || s_op == OP_REARM)) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if ((k >> 5) == int'(s_chunk_index)) begin
                    if (s_op == OP_KEY) begin
                        key_down_reg[k] <= s_key_bits[5'(k)];
                    end else begin
                        rearm_reg[k] <= s_key_bits[5'(k)];
                    end
                end
            end
        end else if (vld_d_reg && !kd) begin
            // released key drops its rearm hold
            rearm_reg[key_d_reg] <= 1'b0;
        end
    end

    // entry selection for the key under process
    always_comb begin
        base_ent = base_rv_reg ? base_rd_reg : 16'h0000;
        fn_ent   = fn_rv_reg ? fn_rd_reg : 16'h0000;
        sel_ent  = (layer_on && (fn_ent != 16'h0000)) ? fn_ent : base_ent;
        contrib  = vld_d_reg && kd && !rm && !is_fn_key;
        ubit     = sel_ent[15:8] - USAGE_FIRST;
        bit_hit  = (sel_ent[15:8] >= USAGE_FIRST) && ({1'b0, ubit} < 9'(BITMAP_BITS));
    end

    // report accumulation
    logic [7:0]             mods_reg;
    logic [BITMAP_BITS-1:0] bitmap_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mods_reg   <= '0;
            bitmap_reg <= '0;
        end else if (contrib) begin
            mods_reg <= mods_reg | sel_ent[7:0];
            for (int b = 0; b < BITMAP_BITS; b++) begin
                if (bit_hit && ({1'b0, ubit} == 9'(b))) begin
                    bitmap_reg[b] <= 1'b1;
                end
            end
        end
    end

    // report byte select
    always_comb begin
        m_byte_value = 8'h00;
        if (cmd.byte_idx == '0) begin
            m_byte_value = mods_reg;
        end
        for (int j = 2; j < REPORT_BYTES; j++) begin
            if (cmd.byte_idx == BYTE_W'(j)) begin
                m_byte_value = bitmap_reg[(j - 2) * 8 +: 8];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nkro_report_builder_core.sv -----
// top level of the nkro report builder: controller, datapath and checks
// depends on nrb_pkg, nrb_ctrl, nrb_datapath and assert_macros.svh
`default_nettype none

// Map writes (op 0, op 1) and rearm or key chunk loads (op 2, op 3 without
// last_chunk) are each taken in a single transaction. A key chunk with
// last_chunk set starts a report: the accept, then a walk over all NUM_KEYS
// keys through the single read port of the map memories, a drain state,
// then REPORT_BYTES result transactions, one per cycle while m_ready is
// high. With map_valid clear the walk is skipped and the all-zero report
// follows the accept directly. No new input is taken until the last report
// byte has gone. The maps need no clearing pass after reset: each entry
// carries a written flag and reads as zero until written. The configuration
// port is always ready.
module nkro_report_builder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [6:0]  s_key_index,
    input  wire logic [7:0]  s_usage_code,
    input  wire logic [7:0]  s_modifier_bits,
    input  wire logic [1:0]  s_chunk_index,
    input  wire logic [31:0] s_key_bits,
    input  wire logic        s_last_chunk,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_byte_index,
    output logic [7:0]       m_byte_value,
    output logic             m_last_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import nrb_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    rpt_start;
    logic    last_ok;
    logic    out_done;

    assign cfg_ready = 1'b1;

    nrb_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_last_chunk (s_last_chunk),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_index (m_byte_index),
        .m_last_byte  (m_last_byte),
        .status       (status),
        .cmd          (cmd)
    );

    nrb_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_op            (s_op),
        .s_key_index     (s_key_index),
        .s_usage_code    (s_usage_code),
        .s_modifier_bits (s_modifier_bits),
        .s_chunk_index   (s_chunk_index),
        .s_key_bits      (s_key_bits),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_byte_value    (m_byte_value)
    );

    // terms for the checks below
    assign rpt_start = s_valid && s_ready && (s_op == OP_KEY) && s_last_chunk;
    assign last_ok   = !(m_valid && m_last_byte) || (m_byte_index == 4'(REPORT_BYTES - 1));
    assign out_done  = m_valid && m_ready && m_last_byte;

    `include "assert_macros.svh"

    // input side and result side never open together
    `NRB_ASSERT(a_no_overlap, !(s_ready && m_valid), "input ready while report in flight")
    // final byte carries the last report position
    `NRB_ASSERT(a_last_index, last_ok, "last byte at wrong index")
    // a report-starting transaction closes the input side
    `NRB_ASSERT_IMP(a_start_busy, rpt_start, !s_ready, "input still ready after report start")
    // taking the last byte reopens the input side
    `NRB_ASSERT_IMP(a_end_idle, out_done, s_ready && !m_valid, "not idle after last byte")

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for nkro_report_builder_core
// predicts every report byte from its own copy of the key maps and key state
// depends on nrb_pkg and the rtl under hdl
`timescale 1ns / 1ps

module testbench;
    import nrb_pkg::*;

    localparam int ITEM_TARGET    = 220;
    localparam int MAP_START      = 2;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 120;
    localparam int STALL_LIMIT    = 2000;
    localparam int SHOW_ERRORS    = 10;

    typedef struct {
        op_t         op;
        logic [6:0]  key_index;
        logic [7:0]  usage_code;
        logic [7:0]  modifier_bits;
        logic [1:0]  chunk_index;
        logic [31:0] key_bits;
        logic        last_chunk;
    } scan_item_t;

    typedef struct {
        logic [3:0] index;
        logic [7:0] value;
        logic       last;
    } report_byte_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op            = '0;
    logic [6:0]  s_key_index     = '0;
    logic [7:0]  s_usage_code    = '0;
    logic [7:0]  s_modifier_bits = '0;
    logic [1:0]  s_chunk_index   = '0;
    logic [31:0] s_key_bits      = '0;
    logic        s_last_chunk    = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [3:0]  m_byte_index;
    logic [7:0]  m_byte_value;
    logic        m_last_byte;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index       = '0;
    logic [7:0]  cfg_data        = '0;

    // predicted state of the block
    logic [7:0] mdl_base_usage [NUM_KEYS];
    logic [7:0] mdl_base_mods  [NUM_KEYS];
    logic [7:0] mdl_fn_usage   [NUM_KEYS];
    logic [7:0] mdl_fn_mods    [NUM_KEYS];
    logic       mdl_down       [NUM_KEYS];
    logic       mdl_rearm      [NUM_KEYS];
    logic       mdl_map_valid;
    logic       mdl_fn_enable;
    logic [7:0] mdl_fn_key;

    report_byte_t pending_bytes[$];
    logic [31:0]  held_bits [3];
    int           byte_errors   = 0;
    int           items_sent    = 0;
    int           stall_cycles  = 0;
    int           hold_left     = 0;
    bit           hold_request  = 1'b0;
    bit           tx_steady     = 1'b0;
    bit           rx_steady     = 1'b0;

    nkro_report_builder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_key_index     (s_key_index),
        .s_usage_code    (s_usage_code),
        .s_modifier_bits (s_modifier_bits),
        .s_chunk_index   (s_chunk_index),
        .s_key_bits      (s_key_bits),
        .s_last_chunk    (s_last_chunk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_index    (m_byte_index),
        .m_byte_value    (m_byte_value),
        .m_last_byte     (m_last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    task automatic reset_predictor();
        for (int k = 0; k < NUM_KEYS; k++) begin
            mdl_base_usage[k] = '0;
            mdl_base_mods[k]  = '0;
            mdl_fn_usage[k]   = '0;
            mdl_fn_mods[k]    = '0;
            mdl_down[k]       = 1'b0;
            mdl_rearm[k]      = 1'b0;
        end
        mdl_map_valid = 1'b0;
        mdl_fn_enable = 1'b0;
        mdl_fn_key    = 8'd255;
        for (int c = 0; c < 3; c++) begin
            held_bits[c] = '0;
        end
    endtask

    // build the report from the current key state and queue its bytes
    task automatic predict_report();
        logic [7:0]   rep [REPORT_BYTES];
        logic [7:0]   u;
        logic [7:0]   m;
        logic         layer_on;
        int           bitpos;
        int           idx;
        report_byte_t rb;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            rep[i] = '0;
        end
        if (mdl_map_valid) begin
            layer_on = 1'b0;
            if (mdl_fn_enable && mdl_fn_key < NUM_KEYS) begin
                layer_on = mdl_down[mdl_fn_key];
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
                u = mdl_base_usage[k];
                m = mdl_base_mods[k];
                if (!mdl_down[k]) begin
                    // released key rearms
                    mdl_rearm[k] = 1'b0;
                end else if (!mdl_rearm[k] && !(layer_on && k == mdl_fn_key)) begin
                    // non-empty overlay entry wins while the layer is active
                    if (layer_on && (mdl_fn_usage[k] != 0 || mdl_fn_mods[k] != 0)) begin
                        u = mdl_fn_usage[k];
                        m = mdl_fn_mods[k];
                    end
                    rep[0] |= m;
                    if (u >= USAGE_FIRST) begin
                        bitpos = u - USAGE_FIRST;
                        idx    = MAP_START + bitpos / 8;
                        if (idx < REPORT_BYTES) begin
                            rep[idx][bitpos % 8] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < REPORT_BYTES; i++) begin
            rb.index = 4'(i);
            rb.value = rep[i];
            rb.last  = (i == REPORT_BYTES - 1);
            pending_bytes.push_back(rb);
        end
    endtask

    // apply one accepted transaction to the predicted state
    task automatic predict_item(input scan_item_t it);
        int k;
        case (it.op)
            OP_BASE, OP_FN: begin
                if (it.key_index < NUM_KEYS) begin
                    if (it.op == OP_BASE) begin
                        mdl_base_usage[it.key_index] = it.usage_code;
                        mdl_base_mods[it.key_index]  = it.modifier_bits;
                    end else begin
                        mdl_fn_usage[it.key_index] = it.usage_code;
                        mdl_fn_mods[it.key_index]  = it.modifier_bits;
                    end
                end
            end
            default: begin
                // chunk bits past the last key are dropped
                for (int i = 0; i < 32; i++) begin
                    k = it.chunk_index * 32 + i;
                    if (k < NUM_KEYS) begin
                        if (it.op == OP_REARM) begin
                            mdl_rearm[k] = it.key_bits[i];
                        end else begin
                            mdl_down[k] = it.key_bits[i];
                        end
                    end
                end
                if (it.op == OP_KEY && it.last_chunk) begin
                    predict_report();
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // send one transaction, with random idle cycles ahead of it unless tx_steady is set
    task automatic send_item(input scan_item_t it);
        if (!tx_steady) begin
            while ($urandom_range(0, 99) < 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_op            <= it.op;
        s_key_index     <= it.key_index;
        s_usage_code    <= it.usage_code;
        s_modifier_bits <= it.modifier_bits;
        s_chunk_index   <= it.chunk_index;
        s_key_bits      <= it.key_bits;
        s_last_chunk    <= it.last_chunk;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_item(it);
        items_sent++;
    endtask

    // stop offering and wait until every predicted byte has arrived
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_MAP_VALID: mdl_map_valid = data[0];
            CFG_FN_ENABLE: mdl_fn_enable = data[0];
            CFG_FN_KEY:    mdl_fn_key    = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // map entry write, unused fields random
    function automatic scan_item_t map_entry(input op_t op, input int key,
                                             input int usage, input int mods);
        scan_item_t it;
        it.op            = op;
        it.key_index     = 7'(key);
        it.usage_code    = 8'(usage);
        it.modifier_bits = 8'(mods);
        it.chunk_index   = 2'($urandom_range(0, 3));
        it.key_bits      = $urandom;
        it.last_chunk    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // rearm or key chunk, unused fields random
    function automatic scan_item_t chunk_item(input op_t op, input int chunk,
                                              input logic [31:0] bits, input logic last);
        scan_item_t it;
        it.op            = op;
        it.key_index     = 7'($urandom_range(0, 127));
        it.usage_code    = 8'($urandom_range(0, 255));
        it.modifier_bits = 8'($urandom_range(0, 255));
        it.chunk_index   = 2'(chunk);
        it.key_bits      = bits;
        it.last_chunk    = last;
        return it;
    endfunction

    // mostly usages that land in the bitmap
    function automatic int rand_usage();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return $urandom_range(0, 3);
        end else if (pick < 3) begin
            return $urandom_range(116, 255);
        end
        return $urandom_range(4, 115);
    endfunction

    // modifiers are ORed, so keep most of them sparse
    function automatic int rand_mods();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return 0;
        end else if (pick < 9) begin
            return 1 << $urandom_range(0, 7);
        end
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] rand_bits();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // one scan: a few map writes, maybe a rearm latch, then the key chunks
    task automatic run_scan(input int n_writes);
        logic [31:0] bits;
        int          n;
        int          key;
        for (int w = 0; w < n_writes; w++) begin
            key = ($urandom_range(0, 9) != 0) ? $urandom_range(0, NUM_KEYS - 1)
                                              : $urandom_range(NUM_KEYS, 127);
            send_item(map_entry($urandom_range(0, 1) ? OP_FN : OP_BASE, key,
                                rand_usage(), rand_mods()));
        end
        if ($urandom_range(0, 3) == 0) begin
            n    = $urandom_range(0, 3);
            bits = (n < 3 && $urandom_range(0, 1)) ? held_bits[n] : rand_bits();
            send_item(chunk_item(OP_REARM, n, bits, 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 99) < 85) begin
            // well-formed scan, often holding keys over from the last one
            for (int c = 0; c < 3; c++) begin
                case ($urandom_range(0, 3))
                    0:       bits = held_bits[c];
                    1:       bits = held_bits[c] ^ (32'h1 << $urandom_range(0, 31));
                    default: bits = rand_bits();
                endcase
                held_bits[c] = bits;
                send_item(chunk_item(OP_KEY, c, bits, c == 2));
            end
        end else begin
            // broken scan with any chunk order and any last flag
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_item(chunk_item(OP_KEY, $urandom_range(0, 3), rand_bits(),
                                     1'($urandom_range(0, 1))));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // maps not loaded: all-zero report, rearm latch kept
    task automatic test_unloaded_map();
        send_item(chunk_item(OP_REARM, 1, 32'hFFFF_FFFF, 1'b0));
        send_item(chunk_item(OP_KEY, 0, 32'hFFFF_FFFF, 1'b0));
        send_item(chunk_item(OP_KEY, 2, 32'hFFFF_FFFF, 1'b1));
    endtask

    // field extremes, absent keys and usages outside the bitmap
    task automatic test_map_extremes();
        wait_for_idle();
        write_reg(CFG_MAP_VALID, 8'd1);
        send_item(map_entry(OP_BASE, 0, 8'h04, 8'h01));
        send_item(map_entry(OP_BASE, 1, 8'h03, 8'h02));
        send_item(map_entry(OP_BASE, 2, 8'h73, 8'h00));
        send_item(map_entry(OP_BASE, 3, 8'h74, 8'h00));
        send_item(map_entry(OP_BASE, NUM_KEYS - 1, 8'hFF, 8'h80));
        send_item(map_entry(OP_BASE, 127, 8'h05, 8'h04));
        send_item(chunk_item(OP_KEY, 0, 32'h0000_000F, 1'b0));
        send_item(chunk_item(OP_KEY, 1, 32'h0000_0000, 1'b0));
        send_item(chunk_item(OP_KEY, 2, 32'hFFFF_F000, 1'b1));
        send_item(chunk_item(OP_KEY, 3, 32'hFFFF_FFFF, 1'b1));
    endtask

    // overlay layer on key 0, then an fn key that does not exist
    task automatic test_fn_layer();
        wait_for_idle();
        write_reg(CFG_FN_ENABLE, 8'd1);
        write_reg(CFG_FN_KEY, 8'd0);
        send_item(map_entry(OP_FN, 1, 8'h10, 8'h08));
        send_item(map_entry(OP_FN, 2, 8'h00, 8'h00));
        send_item(map_entry(OP_FN, 3, 8'h00, 8'h40));
        send_item(chunk_item(OP_KEY, 0, 32'h0000_000F, 1'b1));
        wait_for_idle();
        write_reg(CFG_FN_KEY, 8'(NUM_KEYS));
        send_item(chunk_item(OP_KEY, 0, 32'h0000_000F, 1'b1));
    endtask

    // held keys stay silent until released, then sound again
    task automatic test_rearm();
        send_item(map_entry(OP_BASE, 32, 8'h20, 8'h10));
        send_item(chunk_item(OP_KEY, 1, 32'h0000_0001, 1'b1));
        send_item(chunk_item(OP_KEY, 1, 32'h0000_0000, 1'b1));
        send_item(chunk_item(OP_KEY, 1, 32'h0000_0001, 1'b1));
        send_item(chunk_item(OP_REARM, 2, 32'hFFFF_FFFF, 1'b0));
        send_item(chunk_item(OP_KEY, 2, 32'h0000_1000, 1'b1));
    endtask

    // receiver holds off while scans keep coming, then the sender drains
    task automatic test_receiver_stall();
        wait_for_idle();
        tx_steady    = 1'b1;
        hold_request = 1'b1;
        repeat (3) run_scan(2);
        tx_steady = 1'b0;
        wait_for_idle();
    endtask

    // back-to-back transactions on both sides
    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (6) run_scan($urandom_range(0, 3));
        wait_for_idle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // random scans with a fresh setting every few of them
    task automatic test_random_scans();
        int phase;
        int pick;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase % 6 == 0) begin
                wait_for_idle();
                write_reg(CFG_MAP_VALID, (phase % 30 == 12) ? 8'd0 : 8'd1);
                write_reg(CFG_FN_ENABLE, 8'($urandom_range(0, 3) != 0));
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       write_reg(CFG_FN_KEY, 8'd0);
                    1:       write_reg(CFG_FN_KEY, 8'(NUM_KEYS - 1));
                    2:       write_reg(CFG_FN_KEY, 8'(NUM_KEYS));
                    3:       write_reg(CFG_FN_KEY, 8'd255);
                    default: write_reg(CFG_FN_KEY, 8'($urandom_range(0, NUM_KEYS - 1)));
                endcase
            end
            run_scan($urandom_range(0, 4));
            phase++;
        end
    endtask

    // ---------------------------------------------------------------
    // receiver, checker and watchdog
    // ---------------------------------------------------------------

    // ready with random gaps, or a long hold when requested
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = RX_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    // compare each result transaction with the oldest predicted byte
    always @(posedge aclk) begin : check_bytes
        report_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                byte_errors++;
                if (byte_errors <= SHOW_ERRORS) begin
                    $display("unexpected report byte: idx %0d val %02h last %0b",
                             m_byte_index, m_byte_value, m_last_byte);
                end
            end else begin
                want = pending_bytes.pop_front();
                if (m_byte_index !== want.index || m_byte_value !== want.value ||
                    m_last_byte !== want.last) begin
                    byte_errors++;
                    if (byte_errors <= SHOW_ERRORS) begin
                        $display("report byte mismatch: expected idx %0d val %02h last %0b",
                                 want.index, want.value, want.last,
                                 ", got idx %0d val %02h last %0b",
                                 m_byte_index, m_byte_value, m_last_byte);
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        reset_predictor();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unloaded_map();
        test_map_extremes();
        test_fn_layer();
        test_rearm();
        test_receiver_stall();
        test_steady_stream();
        test_random_scans();

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (byte_errors == 0 && pending_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
